// ===== hw/rtl/b64enc_pkg.sv =====
package b64enc_pkg;

    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
    localparam logic [6:0] CHAR_PLUS    = 7'h2b;
    localparam logic [6:0] CHAR_SLASH   = 7'h2f;
    localparam logic [6:0] CHAR_PAD     = 7'h3d;

    localparam logic [5:0] SEXT_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXT_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXT_PLUS       = 6'd62;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_SPARE  = 2'd3;

    localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

    // one encoded group waiting for the output side
    typedef struct packed {
        logic [3:0][5:0] sext;
        logic [1:0]      pos;
        logic            last;
    } b64enc_grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } b64enc_qstat_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v < SEXT_LOWER_BASE) begin
            return CHAR_UPPER_A + w;
        end else if (v < SEXT_DIGIT_BASE) begin
            return CHAR_LOWER_A + w - {1'b0, SEXT_LOWER_BASE};
        end else if (v < SEXT_PLUS) begin
            return CHAR_DIGIT_0 + w - {1'b0, SEXT_DIGIT_BASE};
        end else if (v == SEXT_PLUS) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

// ===== hw/rtl/b64enc_front.sv =====
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          push,
    output b64enc_grp_t   grp
);

    logic [1:0] pos_reg, pos_next;
    logic [7:0] held_reg [2];
    logic [1:0] pos_eff;
    logic       complete;
    logic [7:0] b0, b1, b2;

    assign pos_eff  = (pos_reg == POS_SPARE) ? POS_THIRD : pos_reg;
    assign complete = in_last || (pos_eff == POS_THIRD);

    always_comb begin
        b0 = (pos_eff == POS_FIRST) ? in_byte : held_reg[0];
        if (pos_eff == POS_SECOND) begin
            b1 = in_byte;
        end else if (pos_eff == POS_THIRD) begin
            b1 = held_reg[1];
        end else begin
            b1 = 8'h00;
        end
        b2 = (pos_eff == POS_THIRD) ? in_byte : 8'h00;
    end

    always_comb begin
        grp.sext[0] = b0[7:2];
        grp.sext[1] = {b0[1:0], b1[7:4]};
        grp.sext[2] = {b1[3:0], b2[7:6]};
        grp.sext[3] = b2[5:0];
        grp.pos     = pos_eff;
        grp.last    = in_last;
    end

    assign push = in_fire && complete;

    always_comb begin
        pos_next = pos_reg;
        if (in_fire) begin
            pos_next = complete ? POS_FIRST : pos_eff + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_FIRST;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && !complete) begin
            held_reg[pos_eff[0]] <= in_byte;
        end
    end

endmodule

// ===== hw/rtl/b64enc_fifo.sv =====
module b64enc_fifo
    import b64enc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  b64enc_grp_t   push_grp,
    input  logic          pop,
    output b64enc_grp_t   head_grp,
    output b64enc_qstat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64enc_grp_t    mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_grp   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

// ===== hw/rtl/b64enc_back.sv =====
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  b64enc_qstat_t qstat,
    input  b64enc_grp_t   head_grp,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [6:0]    out_char,
    output logic          out_eog,
    output logic          out_eom
);

    logic        cur_valid_reg, cur_valid_next;
    b64enc_grp_t cur_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        finish;
    logic        is_pad;

    assign finish = cur_valid_reg && out_ready && (idx_reg == CHAR_IDX_LAST);
    assign pop    = !qstat.empty && (!cur_valid_reg || finish);

    // characters past pos + 1 are padding
    assign is_pad = ({1'b0, idx_reg} > ({1'b0, cur_reg.pos} + 3'd1));

    assign out_valid = cur_valid_reg;
    assign out_char  = is_pad ? CHAR_PAD : sextet_char(cur_reg.sext[idx_reg]);
    assign out_eog   = (idx_reg == CHAR_IDX_LAST);
    assign out_eom   = out_eog && cur_reg.last;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (cur_valid_reg && out_ready) begin
            idx_next = idx_reg + 2'd1;
        end
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (finish) begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_grp;
        end
    end

endmodule

// ===== hw/rtl/base64_encoder.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
// m_        out  m_tvalid/m_tready  m_tdata = out_char, m_tuser = end_of_group,
//                                   m_tlast = end_of_message
//
// one byte is taken per cycle while the group queue has room
// each group of three bytes (or the final partial group) gives four characters,
// one per cycle from the output register while m_tready is high, so the output
// port sets the sustained rate of the block
// reset is synchronous and active low; it clears the group position, the queue
// and the output side, and the block is ready on the first cycle after it
// a stalled output fills the queue, after which s_tready drops
module base64_encoder
    import b64enc_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tuser,   // [0] end_of_group
    output logic       m_tlast
);

    b64enc_grp_t   push_grp;
    b64enc_grp_t   head_grp;
    b64enc_qstat_t qstat;
    logic          push;
    logic          pop;
    logic          in_fire;
    logic [6:0]    out_char;

    assign s_tready = !qstat.full;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tdata  = {1'b0, out_char};

    b64enc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .grp      (push_grp)
    );

    b64enc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head_grp (head_grp),
        .stat     (qstat)
    );

    b64enc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .head_grp  (head_grp),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_eog   (m_tuser),
        .out_eom   (m_tlast)
    );

endmodule

// ===== hw/rtl/b64enc_checker.sv =====
module b64enc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output transaction changed while stalled");

    // end of message only on the end of a group
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
    else $error("end of message away from group end");

    // padding runs to the end of its group
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tdata[6:0] == 7'h3d) && !m_tuser
            |=> m_tvalid && (m_tdata[6:0] == 7'h3d))
    else $error("padding not carried to group end");

    // characters are seven-bit ascii
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
    else $error("character above seven bits");

endmodule

bind base64_encoder b64enc_checker u_b64enc_checker (.*);
